// ===== sv/itp_pkg.sv =====
package itp_pkg;

    // defaults for the top-level parameters
    localparam int STACK_DEPTH_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // field widths
    localparam int TOKEN_KIND_W = 3;
    localparam int OP_W         = 2;
    localparam int OPERAND_W    = 32;
    localparam int OUT_KIND_W   = 2;
    localparam int STACK_CODE_W = 3;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    // input token kinds
    localparam logic [TOKEN_KIND_W-1:0] KIND_OPERAND  = 3'd0;
    localparam logic [TOKEN_KIND_W-1:0] KIND_OPERATOR = 3'd1;
    localparam logic [TOKEN_KIND_W-1:0] KIND_OPEN     = 3'd2;
    localparam logic [TOKEN_KIND_W-1:0] KIND_CLOSE    = 3'd3;
    localparam logic [TOKEN_KIND_W-1:0] KIND_END      = 3'd4;

    // result kinds
    localparam logic [OUT_KIND_W-1:0] OUT_OPERAND  = 2'd0;
    localparam logic [OUT_KIND_W-1:0] OUT_OPERATOR = 2'd1;
    localparam logic [OUT_KIND_W-1:0] OUT_END      = 2'd2;

    // stack entry holding an open paren; operator codes 0..3 are stored as is
    localparam logic [STACK_CODE_W-1:0] OPEN_MARK = 3'd4;

    // one result from the sequencer to the output register
    typedef struct packed {
        logic                  valid;
        logic [OUT_KIND_W-1:0] kind;
        logic [OP_W-1:0]       op;
        logic [OPERAND_W-1:0]  value;
        logic                  last;
        logic                  err;
    } emit_t;

endpackage

// ===== sv/itp_stack_ram.sv =====
module itp_stack_ram
    import itp_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [STACK_CODE_W-1:0]       wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [STACK_CODE_W-1:0]       rdata
);

    logic [STACK_CODE_W-1:0] mem [DEPTH];
    logic [STACK_CODE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/itp_seq.sv =====
module itp_seq
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [TOKEN_KIND_W-1:0]          in_kind,
    input  logic [OP_W-1:0]                  in_op,
    input  logic [OPERAND_W-1:0]             in_value,
    input  logic                             out_free,
    output emit_t                            emit,
    output logic                             ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0]   ram_waddr,
    output logic [STACK_CODE_W-1:0]          ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(STACK_DEPTH)-1:0]   ram_raddr,
    input  logic [STACK_CODE_W-1:0]          ram_rdata
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int KEEP_W = (VALUE_WIDTH < OPERAND_W) ? VALUE_WIDTH : OPERAND_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [SP_W-1:0]         sp_reg, sp_next;
    logic [SP_W-1:0]         open_cnt_reg, open_cnt_next;
    logic                    error_seen_reg, error_seen_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    ret_idle_reg, ret_idle_next;
    logic [TOKEN_KIND_W-1:0] kind_reg, kind_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [KEEP_W-1:0]       val_reg, val_next;
    logic                    err_reg, err_next;
    logic [STACK_CODE_W-1:0] top_reg, top_next;
    logic [OP_W-1:0]         pend_op_reg, pend_op_next;

    logic sp_zero, sp_full, top_open, refill, pend_clear, qualify;

    assign sp_zero    = (sp_reg == '0);
    assign sp_full    = (sp_reg == SP_W'(STACK_DEPTH));
    assign top_open   = (top_reg == OPEN_MARK);
    assign refill     = (sp_reg >= SP_W'(2));
    assign pend_clear = !pend_valid_reg || out_free;
    // stacked operator of equal or higher precedence
    assign qualify    = !sp_zero && !top_open && (top_reg[1] >= op_reg[1]);

    always_comb begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        open_cnt_next   = open_cnt_reg;
        error_seen_next = error_seen_reg;
        pend_valid_next = pend_valid_reg;
        ret_idle_next   = ret_idle_reg;
        kind_next       = kind_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        err_next        = err_reg;
        top_next        = top_reg;
        pend_op_next    = pend_op_reg;
        emit            = '0;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_W'(sp_reg - SP_W'(1));
        ram_wdata       = top_reg;
        ram_re          = 1'b0;
        ram_raddr       = ADDR_W'(sp_reg - SP_W'(2));
        in_ready        = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    kind_next  = in_kind;
                    op_next    = in_op;
                    val_next   = in_value[KEEP_W-1:0];
                    // error of the whole item is known before its first result
                    err_next   = error_seen_reg
                               | ((in_kind == KIND_CLOSE) && (open_cnt_reg == '0))
                               | ((in_kind == KIND_END) && (open_cnt_reg != '0));
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (kind_reg) inside
                    KIND_OPERAND: begin
                        if (out_free) begin
                            emit.valid = 1'b1;
                            emit.kind  = OUT_OPERAND;
                            emit.value = OPERAND_W'(val_reg);
                            emit.last  = 1'b1;
                            emit.err   = err_reg;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_OPEN: begin
                        if (sp_full) begin
                            error_seen_next = 1'b1;
                        end else begin
                            ram_we        = !sp_zero;
                            top_next      = OPEN_MARK;
                            sp_next       = sp_reg + SP_W'(1);
                            open_cnt_next = open_cnt_reg + SP_W'(1);
                        end
                        state_next = ST_IDLE;
                    end
                    KIND_OPERATOR, KIND_CLOSE, KIND_END: begin
                        if (!sp_zero && !top_open
                                && (qualify || kind_reg != KIND_OPERATOR)) begin
                            // pop and hold the operator until its last flag is known
                            if (pend_clear) begin
                                emit.valid      = pend_valid_reg;
                                emit.kind       = OUT_OPERATOR;
                                emit.op         = pend_op_reg;
                                emit.err        = err_reg;
                                pend_valid_next = 1'b1;
                                pend_op_next    = top_reg[OP_W-1:0];
                                sp_next         = sp_reg - SP_W'(1);
                                ret_idle_next   = 1'b0;
                                if (refill) begin
                                    ram_re     = 1'b1;
                                    state_next = ST_FETCH;
                                end
                            end
                        end else if (kind_reg == KIND_END && !sp_zero) begin
                            // leftover open paren, dropped silently
                            sp_next       = sp_reg - SP_W'(1);
                            open_cnt_next = open_cnt_reg - SP_W'(1);
                            ret_idle_next = 1'b0;
                            if (refill) begin
                                ram_re     = 1'b1;
                                state_next = ST_FETCH;
                            end
                        end else if (kind_reg == KIND_END) begin
                            if (pend_valid_reg) begin
                                if (out_free) begin
                                    emit.valid      = 1'b1;
                                    emit.kind       = OUT_OPERATOR;
                                    emit.op         = pend_op_reg;
                                    emit.err        = err_reg;
                                    pend_valid_next = 1'b0;
                                end
                            end else if (out_free) begin
                                emit.valid      = 1'b1;
                                emit.kind       = OUT_END;
                                emit.last       = 1'b1;
                                emit.err        = err_reg;
                                error_seen_next = 1'b0;
                                state_next      = ST_IDLE;
                            end
                        end else if (pend_clear) begin
                            // item ends here: flush the held operator as last
                            emit.valid      = pend_valid_reg;
                            emit.kind       = OUT_OPERATOR;
                            emit.op         = pend_op_reg;
                            emit.last       = 1'b1;
                            emit.err        = err_reg;
                            pend_valid_next = 1'b0;
                            error_seen_next = err_reg;
                            state_next      = ST_IDLE;
                            if (kind_reg == KIND_OPERATOR) begin
                                if (sp_full) begin
                                    error_seen_next = 1'b1;
                                end else begin
                                    ram_we   = !sp_zero;
                                    top_next = STACK_CODE_W'(op_reg);
                                    sp_next  = sp_reg + SP_W'(1);
                                end
                            end else if (!sp_zero) begin
                                // matching open paren found and discarded
                                sp_next       = sp_reg - SP_W'(1);
                                open_cnt_next = open_cnt_reg - SP_W'(1);
                                ret_idle_next = 1'b1;
                                if (refill) begin
                                    ram_re     = 1'b1;
                                    state_next = ST_FETCH;
                                end
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FETCH: begin
                top_next   = ram_rdata;
                state_next = ret_idle_reg ? ST_IDLE : ST_EVAL;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sp_reg         <= '0;
            open_cnt_reg   <= '0;
            error_seen_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            ret_idle_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            open_cnt_reg   <= open_cnt_next;
            error_seen_reg <= error_seen_next;
            pend_valid_reg <= pend_valid_next;
            ret_idle_reg   <= ret_idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        err_reg     <= err_next;
        top_reg     <= top_next;
        pend_op_reg <= pend_op_next;
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_open_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        open_cnt_reg <= sp_reg)
        else $error("more open parens counted than stack entries");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> out_free)
        else $error("result issued into a full output register");

    a_fetch_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> (state_reg != ST_FETCH))
        else $error("refill took more than one cycle");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held operator left behind at end of token");
`endif

endmodule

// ===== sv/infix_to_postfix_converter_unit.sv =====
// Infix to postfix converter (shunting-yard). Each request on the s_ side is one
// infix token; the m_ side returns the postfix tokens it causes, with m_tlast on
// the final one and m_tuser carrying the expression's error flag (unmatched
// paren or stack overflow), identical on all results of one token. Operands pass
// straight through; an operator first pops every stacked operator of equal or
// higher precedence; a close paren pops down to its open paren; end of
// expression drains the stack, emits an end marker and clears the error flag.
// Tokens with unused kind codes, and operators or open parens that pop nothing,
// give no result. Timing: one token at a time. A token is accepted and then
// evaluated; each stack entry popped or dropped takes a pop step and then a refill
// of the cached stack top from the registered-read stack memory; the refill is
// skipped when the stack runs empty, and the pop of the open paren that a close
// paren finds shares the evaluate cycle. An end token that popped operators
// flushes the held operator in a step of its own before its end marker. Stalls on
// m_tready add to this. The stack memory needs no clearing after reset. A new
// token is taken while a result still waits in the output register.
module infix_to_postfix_converter_unit
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // token_kind[2:0], operator_code[4:3], operand_value[36:5], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_kind[1:0], out_operator[3:2], out_value[35:4], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    // error[0]
    output logic                 m_tuser
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    emit_t                   emit;
    logic                    out_free;
    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [STACK_CODE_W-1:0] ram_wdata, ram_rdata;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_KIND_W-1:0]   m_kind_reg;
    logic [OP_W-1:0]         m_op_reg;
    logic [OPERAND_W-1:0]    m_value_reg;
    logic                    m_last_reg;
    logic                    m_err_reg;

    // operator stack entries below the cached top
    itp_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // token sequencer: stack pointer, cached top, pop loop
    itp_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tdata[TOKEN_KIND_W-1:0]),
        .in_op     (s_tdata[TOKEN_KIND_W+OP_W-1:TOKEN_KIND_W]),
        .in_value  (s_tdata[TOKEN_KIND_W+OP_W+OPERAND_W-1:TOKEN_KIND_W+OP_W]),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit.valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_kind_reg  <= emit.kind;
            m_op_reg    <= emit.op;
            m_value_reg <= emit.value;
            m_last_reg  <= emit.last;
            m_err_reg   <= emit.err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_KIND_W - OP_W - OPERAND_W){1'b0}},
                       m_value_reg, m_op_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

endmodule
